// ===== rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Operation and status codes, cell command and cell state records.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int ID_W     = 16;
  localparam int EXP_W    = 32;
  localparam int MAX_POPS = 16;                // most reports one tick may give
  localparam int POP_W    = $clog2(MAX_POPS);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_t;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REINSERT,
    S_TICK
  } state_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [ID_W-1:0]    id;
    logic [EXP_W-1:0]   expiry;
  } cell_ctl_t;

  // contents of one cell
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [EXP_W-1:0]   expiry;
  } cell_state_t;

endpackage

// ===== rtl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted timer chain
// Holds one timer; on insert it takes the new key or its front neighbour,
// on shift it takes its back neighbour.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic                clk,
  input  logic                rst,
  input  stq_pkg::cell_ctl_t  ctl,
  input  logic                shift,       // removal at or in front of this cell
  input  stq_pkg::cell_state_t front,      // neighbour nearer the head
  input  logic                front_gt,
  input  stq_pkg::cell_state_t back,       // neighbour nearer the tail
  output stq_pkg::cell_state_t cur,
  output logic                gt,          // insert point at or in front of here
  output logic                match
);

  stq_pkg::cell_state_t cur_next;

  assign gt    = !cur.valid || (cur.expiry > ctl.expiry);
  assign match = cur.valid && (cur.id == ctl.id);

  always_comb begin
    cur_next = cur;
    case (ctl.cmd)
      stq_pkg::CMD_INSERT: begin
        if (gt) begin
          if (front_gt) begin
            cur_next = front;
          end else begin
            cur_next.valid  = 1'b1;
            cur_next.id     = ctl.id;
            cur_next.expiry = ctl.expiry;
          end
        end
      end
      stq_pkg::CMD_SHIFT: begin
        if (shift) cur_next = back;
      end
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    cur.id     <= cur_next.id;
    cur.expiry <= cur_next.expiry;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue: timers kept in ascending expiry order in a cell chain
// Add, adjust, delete and tick operations over a chain of CAPACITY cells,
// head at cell 0; equal expiries keep arrival order.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                       | tuser       | tlast
//  s_*      | in  | timer_id[15:0] expire_time[47:16]        | operation   | -
//           |     | now_time[79:48]                          |             |
//  m_*      | out | status[1:0] expired_id[17:2], zero pad   | result_kind | last
//
//  Add, delete: done as the operation is taken. Adjust: remove, then re-insert
//  in S_REINSERT. Tick: taken, then each S_TICK step pops the due head timer
//  (at most 16), or reports none due for a tick with nothing due.
//  Reset (rst, synchronous) empties the chain at once; no clearing pass.
//  A stalled m_tready holds the output register and, in a tick, the chain; a
//  new input is taken only when the block is idle and the output register frees.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // timer_id, expire_time, now_time
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status, expired_id, zero pad
  output logic        m_tuser,   // result_kind
  output logic        m_tlast
);

  // input fields
  logic [stq_pkg::ID_W-1:0]  in_id;
  logic [stq_pkg::EXP_W-1:0] in_exp;
  logic [stq_pkg::EXP_W-1:0] in_now;
  stq_pkg::op_t              in_op;

  assign in_id  = s_tdata[15:0];
  assign in_exp = s_tdata[47:16];
  assign in_now = s_tdata[79:48];
  assign in_op  = stq_pkg::op_t'(s_tuser);

  // held operands for the multi-cycle operations
  stq_pkg::state_t           state, state_next;
  logic [stq_pkg::ID_W-1:0]  id_r;
  logic [stq_pkg::EXP_W-1:0] exp_r;
  logic [stq_pkg::EXP_W-1:0] now_r;
  logic [stq_pkg::POP_W-1:0] pop_cnt, pop_cnt_next;

  // output register
  logic                      out_valid;
  logic                      out_kind;
  stq_pkg::status_t          out_status;
  logic [stq_pkg::ID_W-1:0]  out_id;
  logic                      out_last;

  logic                      emit;
  logic                      emit_kind;
  stq_pkg::status_t          emit_status;
  logic [stq_pkg::ID_W-1:0]  emit_id;
  logic                      emit_last;

  logic                      ofree;
  logic                      accept;

  // chain
  stq_pkg::cell_ctl_t        ctl;
  stq_pkg::cell_state_t      cs [CAPACITY];
  logic [CAPACITY-1:0]       gt_vec;
  logic [CAPACITY-1:0]       match_vec;
  logic [CAPACITY-1:0]       neg_match;
  logic [CAPACITY-1:0]       hit_tail;   // front-most match and all behind it
  logic [CAPACITY-1:0]       shift_vec;
  logic [CAPACITY-1:0]       valid_vec;
  logic                      found;
  logic                      full;
  logic                      due0, due1;

  assign ofree    = !out_valid || m_tready;
  assign s_tready = (state == stq_pkg::S_IDLE) && ofree;
  assign accept   = s_tvalid && s_tready;

  // x | -x sets every bit from the lowest set bit upward
  assign neg_match = ~match_vec + {{(CAPACITY-1){1'b0}}, 1'b1};
  assign hit_tail  = match_vec | neg_match;
  assign found     = |match_vec;
  assign full      = cs[CAPACITY-1].valid;
  assign due0      = cs[0].valid && (cs[0].expiry <= now_r);
  assign due1      = cs[1].valid && (cs[1].expiry <= now_r);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    stq_pkg::cell_state_t front_s, back_s;
    logic                 front_gt;

    if (i == 0) begin : g_head
      assign front_s  = '0;
      assign front_gt = 1'b0;
    end else begin : g_mid
      assign front_s  = cs[i-1];
      assign front_gt = gt_vec[i-1];
    end
    if (i == CAPACITY-1) begin : g_tail
      assign back_s = '0;
    end else begin : g_body
      assign back_s = cs[i+1];
    end

    stq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift    (shift_vec[i]),
      .front    (front_s),
      .front_gt (front_gt),
      .back     (back_s),
      .cur      (cs[i]),
      .gt       (gt_vec[i]),
      .match    (match_vec[i])
    );

    assign valid_vec[i] = cs[i].valid;
  end

  // sequencer: next state, chain command and the result to register
  always_comb begin
    state_next   = state;
    pop_cnt_next = pop_cnt;
    ctl.cmd      = stq_pkg::CMD_HOLD;
    ctl.id       = in_id;
    ctl.expiry   = in_exp;
    shift_vec    = hit_tail;
    emit         = 1'b0;
    emit_kind    = stq_pkg::KIND_STATUS;
    emit_status  = stq_pkg::ST_OK;
    emit_id      = '0;
    emit_last    = 1'b1;
    case (state)
      stq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            stq_pkg::OP_ADD: begin
              emit = 1'b1;
              if (full) begin
                emit_status = stq_pkg::ST_FULL;
              end else begin
                ctl.cmd = stq_pkg::CMD_INSERT;
              end
            end
            stq_pkg::OP_ADJUST, stq_pkg::OP_DELETE: begin
              emit = 1'b1;
              if (!found) begin
                emit_status = stq_pkg::ST_NOT_FOUND;
              end else begin
                ctl.cmd = stq_pkg::CMD_SHIFT;
                if (in_op == stq_pkg::OP_ADJUST) state_next = stq_pkg::S_REINSERT;
              end
            end
            default: begin
              pop_cnt_next = '0;
              state_next   = stq_pkg::S_TICK;
            end
          endcase
        end
      end
      stq_pkg::S_REINSERT: begin
        // room is certain: one entry was just removed
        ctl.cmd    = stq_pkg::CMD_INSERT;
        ctl.id     = id_r;
        ctl.expiry = exp_r;
        state_next = stq_pkg::S_IDLE;
      end
      stq_pkg::S_TICK: begin
        if (ofree) begin
          emit = 1'b1;
          if (due0) begin
            shift_vec    = '1;
            ctl.cmd      = stq_pkg::CMD_SHIFT;
            emit_kind    = stq_pkg::KIND_EXPIRED;
            emit_id      = cs[0].id;
            emit_last    = !due1 || (pop_cnt == stq_pkg::POP_W'(stq_pkg::MAX_POPS - 1));
            pop_cnt_next = pop_cnt + 1'b1;
            if (emit_last) state_next = stq_pkg::S_IDLE;
          end else begin
            // reached only on the first step: later steps know ahead
            emit_status = stq_pkg::ST_NONE_DUE;
            state_next  = stq_pkg::S_IDLE;
          end
        end
      end
      default: state_next = stq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_cnt <= pop_cnt_next;
    if (accept) begin
      id_r  <= in_id;
      exp_r <= in_exp;
      now_r <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_status <= emit_status;
      out_id     <= emit_id;
      out_last   <= emit_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_id, out_status};

  // ordering of held timers: adjacent valid cells never step backwards
  logic order_ok;
  always_comb begin
    order_ok = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      if (cs[i].valid && (cs[i].expiry < cs[i-1].expiry)) order_ok = 1'b0;
    end
  end

  // valid cells always form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
    else $error("valid cells not contiguous from the head");

  a_sorted: assert property (@(posedge clk) disable iff (rst) order_ok)
    else $error("chain out of expiry order");

  a_full_reply: assert property (@(posedge clk) disable iff (rst)
    accept && (in_op == stq_pkg::OP_ADD) && full |=>
      m_tvalid && (out_status == stq_pkg::ST_FULL) && !$changed(valid_vec))
    else $error("add to a full chain not refused");

  a_report_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == stq_pkg::KIND_EXPIRED) |-> (out_status == stq_pkg::ST_OK))
    else $error("expired report with non-zero status");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::S_TICK) && emit && (emit_kind == stq_pkg::KIND_EXPIRED) |=>
      $countones(valid_vec) + 1 == $countones($past(valid_vec)))
    else $error("pop did not remove the head timer");

endmodule

// ===== sim/tb_sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue: self-checking bench for the sorted timer queue
// Shadows the timer list in a queue of its own and works out the replies and
// expiry reports of every accepted operation. A directed run covers the empty,
// full, duplicate and full-drain cases. Random traffic then follows in three
// phases, the last without idling; each output is compared field by field.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;

  localparam int CAPACITY       = 16;
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 40;    // longer than a full drain of pops

  // one operation as the sender presents it
  typedef struct {
    stq_pkg::op_t              op;
    logic [stq_pkg::ID_W-1:0]  id;
    logic [stq_pkg::EXP_W-1:0] expiry;
    logic [stq_pkg::EXP_W-1:0] now;
    bit                        hold;  // wait for every outstanding reply first
  } timer_op_t;

  // one output transfer as the block should give it
  typedef struct {
    logic                     kind;
    stq_pkg::status_t         status;
    logic [stq_pkg::ID_W-1:0] id;
    logic                     last;
  } reply_t;

  typedef struct {
    logic [stq_pkg::ID_W-1:0]  id;
    logic [stq_pkg::EXP_W-1:0] expiry;
  } timer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // timer_id, expire_time, now_time
  logic [1:0]  s_tuser = '0;   // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // status, expired_id, zero pad
  logic        m_tuser;        // result_kind
  logic        m_tlast;

  timer_op_t op_backlog[$];      // operations not yet presented
  timer_op_t op_on_bus;          // operation held on the input bus
  timer_t    held_timers[$];     // shadow of the chain, head first
  reply_t    pending_replies[$]; // replies still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  logic [stq_pkg::EXP_W-1:0] sim_now = 32'd100;  // rising notion of time for stimulus

  sorted_timer_queue #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the timer list
  // --------------------------------------------------------------------------
  function automatic void owe_status(stq_pkg::status_t st);
    pending_replies.push_back('{stq_pkg::KIND_STATUS, st, '0, 1'b1});
  endfunction

  // new or moved timers go behind every equal expiry
  function automatic void insert_timer(logic [stq_pkg::ID_W-1:0] id,
                                       logic [stq_pkg::EXP_W-1:0] expiry);
    int pos;
    pos = 0;
    while (pos < held_timers.size() && held_timers[pos].expiry <= expiry) pos++;
    held_timers.insert(pos, '{id, expiry});
  endfunction

  function automatic void apply_timer_op(timer_op_t t);
    int pos;
    int pops;
    pos  = -1;
    pops = 0;
    case (t.op)
      stq_pkg::OP_ADD: begin
        if (held_timers.size() >= CAPACITY) begin
          owe_status(stq_pkg::ST_FULL);
        end else begin
          insert_timer(t.id, t.expiry);
          owe_status(stq_pkg::ST_OK);
        end
      end
      stq_pkg::OP_ADJUST, stq_pkg::OP_DELETE: begin
        // duplicates: the one nearest the head is the one acted on
        for (int i = 0; i < held_timers.size() && pos < 0; i++)
          if (held_timers[i].id == t.id) pos = i;
        if (pos < 0) begin
          owe_status(stq_pkg::ST_NOT_FOUND);
        end else begin
          held_timers.delete(pos);
          if (t.op == stq_pkg::OP_ADJUST) insert_timer(t.id, t.expiry);
          owe_status(stq_pkg::ST_OK);
        end
      end
      default: begin  // tick
        while (held_timers.size() > 0 && pops < stq_pkg::MAX_POPS &&
               held_timers[0].expiry <= t.now) begin
          pending_replies.push_back('{stq_pkg::KIND_EXPIRED, stq_pkg::ST_OK,
                                      held_timers[0].id, 1'b0});
          void'(held_timers.pop_front());
          pops++;
        end
        if (pops == 0) owe_status(stq_pkg::ST_NONE_DUE);
        else pending_replies[pending_replies.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the backlog, predicts on every accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_timer_op(op_on_bus);
      if (!s_tvalid || s_tready) begin
        if (op_backlog.size() > 0 &&
            !(op_backlog[0].hold && pending_replies.size() > 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          op_on_bus = op_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= op_on_bus.op;
          s_tdata  <= {op_on_bus.now, op_on_bus.expiry, op_on_bus.id};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result transfer: kind %0d status %0d id %0h last %0d",
                 m_tuser, m_tdata[1:0], m_tdata[17:2], m_tlast);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            mismatches++;
          end
          if (m_tdata[17:2] !== want.id) begin
            $error("expired_id: expected %0h, got %0h", want.id, m_tdata[17:2]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_op(stq_pkg::op_t op, logic [stq_pkg::ID_W-1:0] id,
                          logic [stq_pkg::EXP_W-1:0] expiry,
                          logic [stq_pkg::EXP_W-1:0] now, bit hold = 1'b0);
    op_backlog.push_back('{op, id, expiry, now, hold});
  endtask

  // mostly ids from a small pool and expiries near the running time, so that
  // adjust and delete find their timers and ticks pop a few at a time; the
  // rest is full-range noise
  task automatic queue_random_ops(int count);
    int unsigned pick;
    timer_op_t   t;
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      t.op     = (pick < 35) ? stq_pkg::OP_ADD : (pick < 55) ? stq_pkg::OP_ADJUST :
                 (pick < 72) ? stq_pkg::OP_DELETE : stq_pkg::OP_TICK;
      t.id     = ($urandom_range(0, 9) < 8) ? stq_pkg::ID_W'($urandom_range(0, 11)) :
                                              stq_pkg::ID_W'($urandom);
      t.expiry = ($urandom_range(0, 9) < 9) ? sim_now + $urandom_range(0, 40) : $urandom;
      t.now    = $urandom;
      if (t.op == stq_pkg::OP_TICK && $urandom_range(0, 9) < 9) begin
        sim_now = sim_now + $urandom_range(0, 30);
        t.now   = sim_now;
      end
      t.hold = ($urandom_range(0, 19) == 0);
      op_backlog.push_back(t);
    end
  endtask

  task automatic wait_all_settled();
    while (op_backlog.size() > 0 || s_tvalid || pending_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // phase one: light sender gaps, heavy back-pressure
    send_idle_pct = 10;
    recv_idle_pct = 55;

    // empty list: tick with nothing due, absent ids
    queue_op(stq_pkg::OP_TICK,   stq_pkg::ID_W'($urandom), $urandom, 32'd0);
    queue_op(stq_pkg::OP_DELETE, 16'h0005, $urandom, $urandom);
    queue_op(stq_pkg::OP_ADJUST, 16'hFFFF, 32'd0,    $urandom);
    // fill to capacity: extremes, equal expiries, a duplicate id
    queue_op(stq_pkg::OP_ADD, 16'h0001, 32'd50,        $urandom);
    queue_op(stq_pkg::OP_ADD, 16'h0002, 32'd0,         $urandom);
    queue_op(stq_pkg::OP_ADD, 16'h0003, 32'd50,        $urandom);
    queue_op(stq_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, $urandom);
    queue_op(stq_pkg::OP_ADD, 16'h0001, 32'd20,        $urandom);
    queue_op(stq_pkg::OP_ADD, 16'h0000, 32'd50,        $urandom);
    for (int k = 0; k < 10; k++)
      queue_op(stq_pkg::OP_ADD, stq_pkg::ID_W'(4 + k), stq_pkg::EXP_W'(100 + 10 * k),
               $urandom);
    queue_op(stq_pkg::OP_ADD,    16'h2701, $urandom, $urandom);   // list full
    queue_op(stq_pkg::OP_ADJUST, 16'h0001, 32'd5,    $urandom);   // front duplicate, earlier
    queue_op(stq_pkg::OP_ADJUST, 16'h0000, 32'd200,  $urandom);   // later
    queue_op(stq_pkg::OP_DELETE, 16'h0001, $urandom, $urandom);   // front duplicate goes
    queue_op(stq_pkg::OP_ADD,    16'h8000, 32'h8000_0000, $urandom);
    // every held timer due at once; sender first lets all replies drain
    queue_op(stq_pkg::OP_TICK, stq_pkg::ID_W'($urandom), $urandom, 32'hFFFF_FFFF, 1'b1);

    queue_random_ops(28);
    wait_all_settled();

    // phase two: roles swapped
    send_idle_pct = 55;
    recv_idle_pct = 10;
    queue_random_ops(29);
    wait_all_settled();

    // phase three: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_ops(28);
    wait_all_settled();

    // anything that turns up now is a stray transfer
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
